### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define DSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dsm assertion failed");

// overlapping implication checked outside reset
`define DSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsm implication failed");

// next-cycle implication checked outside reset
`define DSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsm next-cycle implication failed");

`endif

### rtl/dsm_pkg.sv
// types, constants and code tables of the seven-segment display scanner
// no dependencies
package dsm_pkg;

  localparam int unsigned DigitCount = 4;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [DigitCount-1:0] digits_t;

  typedef enum logic [1:0] {
    RegDwell    = 2'd0,
    RegRounds   = 2'd1,
    RegDebounce = 2'd2
  } reg_idx_e;

  localparam logic [15:0] DwellReset    = 16'd1000;
  localparam logic [7:0]  RoundsReset   = 8'd105;
  localparam logic [23:0] DebounceReset = 24'd50000;
  localparam logic [13:0] MaxShown      = 14'd9999;

  typedef struct packed {
    logic [3:0] digit_select;
    logic [7:0] segment_drive;
    logic       debouncing;
  } result_t;

  // segments a..g on bits 6..0, active high
  function automatic logic [6:0] seg_code(input bcd_t d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h7E;
      4'd1:    c = 7'h30;
      4'd2:    c = 7'h6D;
      4'd3:    c = 7'h79;
      4'd4:    c = 7'h33;
      4'd5:    c = 7'h5B;
      4'd6:    c = 7'h5F;
      4'd7:    c = 7'h70;
      4'd8:    c = 7'h7F;
      4'd9:    c = 7'h7B;
      default: c = 7'h7E;
    endcase
    return c;
  endfunction

  // active-low digit enable, units first
  function automatic logic [3:0] select_code(input logic [1:0] idx);
    logic [3:0] s;
    case (idx)
      2'd0:    s = 4'b0111;
      2'd1:    s = 4'b1011;
      2'd2:    s = 4'b1101;
      default: s = 4'b1110;
    endcase
    return s;
  endfunction

endpackage

### rtl/dsm_if.sv
// valid/ready channel interfaces for the display scanner input and result items
// no dependencies
interface dsm_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [15:0] pressure_value;
  logic [15:0] temperature_value;

  modport source (output valid, output button_level, output pressure_value,
                  output temperature_value, input ready);
  modport sink (input valid, input button_level, input pressure_value,
                input temperature_value, output ready);
endinterface

interface dsm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_select;
  logic [7:0] segment_drive;
  logic       debouncing;

  modport source (output valid, output digit_select, output segment_drive,
                  output debouncing, input ready);
  modport sink (input valid, input digit_select, input segment_drive,
                input debouncing, output ready);
endinterface

### rtl/dsm_bcd.sv
// clamps a 16-bit reading to 9999 and splits it into four decimal digits
// uses dsm_pkg; reciprocal multiplies, no divider
module dsm_bcd (
  input  logic [15:0]      value_i,
  output dsm_pkg::digits_t digits_o
);
  import dsm_pkg::*;

  logic [13:0] v;
  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;

  assign v = (value_i > {2'b00, MaxShown}) ? MaxShown : value_i[13:0];

  // exact for values up to 9999
  assign p10   = 30'(v) * 30'd52429;
  assign p100  = 27'(v) * 27'd5243;
  assign p1000 = 28'(v) * 28'd8389;
  assign q10   = p10[28:19];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  assign r0 = v - ({4'd0, q10} << 3) - ({4'd0, q10} << 1);
  assign r1 = q10 - ({3'd0, q100} << 3) - ({3'd0, q100} << 1);
  assign r2 = q100 - ({3'd0, q1000} << 3) - ({3'd0, q1000} << 1);

  assign digits_o[0] = r0[3:0];
  assign digits_o[1] = r1[3:0];
  assign digits_o[2] = r2[3:0];
  assign digits_o[3] = q1000;

endmodule

### rtl/four_digit_seven_segment_mux_display_top.sv
// four-digit multiplexed seven-segment display scanner with button-selected reading
// uses dsm_pkg, dsm_if (dsm_in_if, dsm_out_if) and dsm_bcd
//
// Usage:
//   in_i carries one scan tick per item: button level (low = pressed), pressure
//   and temperature readings. out_o returns exactly one result item per input
//   item: active-low digit select, inverted segment code (bit 7 high) and a
//   flag that is high while the outputs are held for the debounce wait.
//   The APB port sets dwell ticks (0x0), rounds per update (0x4) and debounce
//   ticks (0x8); write them only while no item is in flight.
//   The result of an accepted item is registered and valid in the next cycle.
//   Throughput is one item per cycle unless the receiver stalls; the scan
//   counters, the digit store and the decimal split of a loaded reading all
//   update in the cycle of acceptance, so the next item may follow at once.
//   A single result register sits at the output; while the receiver stalls
//   with it full, in_i.ready stays low and no tick is lost.
//   Reset clears the shown digits to 0000, all scan and debounce counters and
//   flags, and loads the registers with 1000, 105 and 50000.
module four_digit_seven_segment_mux_display_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsm_in_if.sink      in_i,
  dsm_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dsm_pkg::*;

  logic [15:0] dwell_ticks_q;
  logic [7:0]  rounds_q;
  logic [23:0] debounce_ticks_q;

  digits_t     digits_q, digits_d, bcd_digits;
  logic [1:0]  digit_index_q, digit_index_d;
  logic [15:0] dwell_count_q, dwell_count_d;
  logic [7:0]  round_count_q, round_count_d;
  logic [23:0] debounce_count_q, debounce_count_d;
  logic        in_debounce_q, in_debounce_d;
  logic        was_pressed_q, was_pressed_d;
  logic [11:0] held_q, held_d;

  result_t     res_q, res_d;
  logic        out_valid_q;
  logic        accept;
  logic        load;
  logic        confirm_pressed;
  logic [15:0] load_value;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q    <= DwellReset;
      rounds_q         <= RoundsReset;
      debounce_ticks_q <= DebounceReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_e'(paddr[3:2]))
        RegDwell:    dwell_ticks_q    <= pwdata[15:0];
        RegRounds:   rounds_q         <= pwdata[7:0];
        RegDebounce: debounce_ticks_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      RegDwell:    prdata = {16'd0, dwell_ticks_q};
      RegRounds:   prdata = {24'd0, rounds_q};
      RegDebounce: prdata = {8'd0, debounce_ticks_q};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // ---------------- scan step ----------------
  assign load_value = (confirm_pressed && !was_pressed_q) ? in_i.pressure_value
                                                          : in_i.temperature_value;

  dsm_bcd u_bcd (
    .value_i  (load_value),
    .digits_o (bcd_digits)
  );

  always_comb begin
    logic        pressed;
    logic [15:0] dwell_eff;
    logic [7:0]  rounds_eff;
    logic [15:0] dwell_inc;
    logic [7:0]  round_inc;
    logic [23:0] debounce_inc;
    logic [3:0]  sel;
    logic [7:0]  seg;

    pressed      = !in_i.button_level;
    dwell_eff    = (dwell_ticks_q == 16'd0) ? 16'd1 : dwell_ticks_q;
    rounds_eff   = (rounds_q == 8'd0) ? 8'd1 : rounds_q;
    dwell_inc    = dwell_count_q + 16'd1;
    round_inc    = round_count_q + 8'd1;
    debounce_inc = debounce_count_q + 24'd1;
    sel          = select_code(digit_index_q);
    seg          = ~{1'b0, seg_code(digits_q[digit_index_q])};

    digit_index_d    = digit_index_q;
    dwell_count_d    = dwell_count_q;
    round_count_d    = round_count_q;
    debounce_count_d = debounce_count_q;
    in_debounce_d    = in_debounce_q;
    was_pressed_d    = was_pressed_q;
    held_d           = held_q;
    load             = 1'b0;
    confirm_pressed  = pressed;

    if (in_debounce_q) begin
      res_d.digit_select  = held_q[11:8];
      res_d.segment_drive = held_q[7:0];
      res_d.debouncing    = 1'b1;
      debounce_count_d    = debounce_inc;
      if (debounce_inc >= debounce_ticks_q) begin
        in_debounce_d    = 1'b0;
        debounce_count_d = 24'd0;
        load             = 1'b1;
        was_pressed_d    = 1'b1;
      end
    end else begin
      res_d.digit_select  = sel;
      res_d.segment_drive = seg;
      res_d.debouncing    = 1'b0;
      dwell_count_d       = dwell_inc;
      if (dwell_inc >= dwell_eff || dwell_inc == 16'd0) begin
        dwell_count_d = 16'd0;
        digit_index_d = digit_index_q + 2'd1;
        // end of a full round after the thousands digit
        if (digit_index_q == 2'd3) begin
          round_count_d = round_inc;
          if (round_inc >= rounds_eff || round_inc == 8'd0) begin
            round_count_d = 8'd0;
            if (pressed) begin
              if (debounce_ticks_q == 24'd0) begin
                confirm_pressed = 1'b1;
                load            = 1'b1;
                was_pressed_d   = 1'b1;
              end else begin
                in_debounce_d    = 1'b1;
                debounce_count_d = 24'd0;
                held_d           = {sel, seg};
              end
            end else begin
              was_pressed_d = 1'b0;
            end
          end
        end
      end
    end
  end

  assign digits_d = load ? bcd_digits : digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q         <= '0;
      digit_index_q    <= 2'd0;
      dwell_count_q    <= 16'd0;
      round_count_q    <= 8'd0;
      debounce_count_q <= 24'd0;
      in_debounce_q    <= 1'b0;
      was_pressed_q    <= 1'b0;
      held_q           <= 12'd0;
    end else if (accept) begin
      digits_q         <= digits_d;
      digit_index_q    <= digit_index_d;
      dwell_count_q    <= dwell_count_d;
      round_count_q    <= round_count_d;
      debounce_count_q <= debounce_count_d;
      in_debounce_q    <= in_debounce_d;
      was_pressed_q    <= was_pressed_d;
      held_q           <= held_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.digit_select  = res_q.digit_select;
  assign out_o.segment_drive = res_q.segment_drive;
  assign out_o.debouncing    = res_q.debouncing;

endmodule

### rtl/dsm_checker.sv
// port-level checks of the display scanner, bound to the top level
// uses assert_macros.svh and dsm_pkg
`include "assert_macros.svh"

module dsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] digit_select_i,
  input logic [7:0] segment_drive_i,
  input logic       debouncing_i
);
  import dsm_pkg::*;

  result_t shown;
  assign shown = '{digit_select: digit_select_i, segment_drive: segment_drive_i,
                   debouncing: debouncing_i};

  // a stalled result keeps its payload
  `DSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(shown))

  // every accepted item gives a valid result in the next cycle
  `DSM_ASSERT_NEXT(a_item_latency, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i)

  // exactly one digit lit at a time
  `DSM_ASSERT_IMPL(a_one_digit, clk_i, rst_ni, out_valid_i, $onehot(~digit_select_i))

  // decimal point segment always off
  `DSM_ASSERT_IMPL(a_dp_off, clk_i, rst_ni, out_valid_i, segment_drive_i[7])

endmodule

bind four_digit_seven_segment_mux_display_top dsm_checker u_dsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .digit_select_i  (out_o.digit_select),
  .segment_drive_i (out_o.segment_drive),
  .debouncing_i    (out_o.debouncing)
);
